[rtl/core/slpg_pkg.sv]
package slpg_pkg;

	// request codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_STATE = 2'd1;
	localparam logic [1:0] FUNC_EVENT = 2'd2;

	// system state codes
	localparam logic [2:0] MODE_BOOT      = 3'd0;
	localparam logic [2:0] MODE_WIFI      = 3'd1;
	localparam logic [2:0] MODE_NOT_READY = 3'd2;
	localparam logic [2:0] MODE_READY     = 3'd3;
	localparam logic [2:0] MODE_MOVING    = 3'd4;
	localparam logic [2:0] MODE_ERROR     = 3'd5;

	// activity codes
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// configuration register indexes
	localparam logic [2:0] CFG_SLOW_PERIOD  = 3'd0;
	localparam logic [2:0] CFG_FAST_PERIOD  = 3'd1;
	localparam logic [2:0] CFG_BLINK_PERIOD = 3'd2;
	localparam logic [2:0] CFG_ERROR_HOLD   = 3'd3;
	localparam logic [2:0] CFG_FLASH_HOLD   = 3'd4;
	localparam logic [2:0] CFG_BREATH_PEAK  = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// serial divider step counts
	localparam int DIV_STEPS_W = 6;
	localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_MOD = 6'd32;
	localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_LVL = 6'd18;
	localparam logic [DIV_STEPS_W-1:0] DIV_STEPS_AMB = 6'd16;

	localparam logic [7:0] RED_HOLD_R    = 8'd180;
	localparam logic [7:0] ORANGE_R      = 8'd180;
	localparam logic [7:0] ORANGE_G      = 8'd60;
	localparam logic [15:0] AMBER_R_GAIN = 16'd200;

	typedef enum logic [2:0] {
		CAT_AMBER,
		CAT_GREEN,
		CAT_ORANGE,
		CAT_BLUE,
		CAT_WHITE
	} slpg_cat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MOD_WAIT,
		ST_LVL_WAIT,
		ST_AMB_WAIT,
		ST_DONE
	} slpg_state_t;

	typedef struct packed {
		logic accept;
		logic start_mod;
		logic start_lvl;
		logic start_amb;
		logic commit;
	} slpg_cmd_t;

	typedef struct packed {
		logic is_tick;
		logic err_active;
		logic blink;
		logic amber;
		logic peak_zero;
		logic div_done;
		logic out_free;
	} slpg_sts_t;

	function automatic logic [7:0] sat8(input logic [17:0] v);
		sat8 = (v > 18'd255) ? 8'd255 : v[7:0];
	endfunction

	// x / 3 for 8-bit x, exact over the full range
	function automatic logic [7:0] div3(input logic [7:0] x);
		logic [16:0] p;
		p = 17'(x) * 17'd171;
		div3 = p[16:9];
	endfunction

endpackage

[rtl/core/status_led_pattern_generator.sv]
// Flow: state and activity requests, and ticks in the red error hold, go from accept
// via dispatch to done. Other ticks run the shared serial divider, one bit per cycle:
// phase only for the orange blink, phase and level for breathing, amber also if peak != 0.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: arst_n asynchronously clears control and block state and loads register defaults.
module status_led_pattern_generator import slpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             func,
	input  logic [2:0]             new_mode,
	input  logic [1:0]             activity_kind,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   frame_valid,
	output logic                   status,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	slpg_cmd_t cmd;
	slpg_sts_t sts;

	assign cfg_ready = 1'b1;

	slpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	slpg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.new_mode      (new_mode),
		.activity_kind (activity_kind),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.frame_valid   (frame_valid),
		.status        (status)
	);

endmodule

[rtl/core/slpg_div.sv]
module slpg_div import slpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [DIV_STEPS_W-1:0] steps,
	input  logic [31:0]            dividend,
	input  logic [9:0]             divisor,
	output logic                   done,
	output logic [31:0]            quot,
	output logic [9:0]             rem
);

	logic                   busy_q;
	logic                   done_q;
	logic [DIV_STEPS_W-1:0] cnt_q;
	logic [31:0]            dv_q;
	logic [9:0]             rem_q;
	logic [9:0]             dsr_q;
	logic [10:0]            trial;
	logic                   ge;
	logic [10:0]            diff;

	assign trial = {rem_q, dv_q[31]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_STEPS_W'(1);
				if (cnt_q == DIV_STEPS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one quotient bit per cycle, dividend left-aligned
	always_ff @(posedge clk) begin
		if (start) begin
			dv_q  <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[9:0] : trial[9:0];
			dv_q  <= {dv_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dv_q;
	assign rem  = rem_q;

endmodule

[rtl/core/slpg_ctrl.sv]
module slpg_ctrl import slpg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  slpg_sts_t sts,
	output slpg_cmd_t cmd,
	output logic      in_stall
);

	slpg_state_t state_q;
	slpg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (!sts.is_tick || sts.err_active) begin
					state_d = ST_DONE;
				end else begin
					cmd.start_mod = 1'b1;
					state_d       = ST_MOD_WAIT;
				end
			end
			ST_MOD_WAIT: begin
				if (sts.div_done) begin
					if (sts.blink) begin
						state_d = ST_DONE;
					end else begin
						cmd.start_lvl = 1'b1;
						state_d       = ST_LVL_WAIT;
					end
				end
			end
			ST_LVL_WAIT: begin
				if (sts.div_done) begin
					if (sts.amber && !sts.peak_zero) begin
						cmd.start_amb = 1'b1;
						state_d       = ST_AMB_WAIT;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_AMB_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/slpg_dp.sv]
module slpg_dp import slpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slpg_cmd_t              cmd,
	output slpg_sts_t              sts,
	input  logic [1:0]             func,
	input  logic [2:0]             new_mode,
	input  logic [1:0]             activity_kind,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic [7:0]             red,
	output logic [7:0]             green,
	output logic [7:0]             blue,
	output logic                   frame_valid,
	output logic                   status
);

	// configuration
	logic [9:0]  slow_period_q;
	logic [9:0]  fast_period_q;
	logic [9:0]  blink_period_q;
	logic [15:0] error_hold_q;
	logic [7:0]  flash_hold_q;
	logic [7:0]  breath_peak_q;

	// block state
	logic [2:0]  mode_q;
	logic [15:0] error_count_q;
	logic [7:0]  flash_red_q;
	logic [7:0]  flash_green_q;
	logic [7:0]  flash_blue_q;
	logic [7:0]  flash_count_q;
	logic [31:0] tick_count_q;

	// request in flight
	logic [1:0]  func_q;
	logic [2:0]  new_mode_q;
	logic [1:0]  kind_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  red_q;
	logic [7:0]  green_q;
	logic [7:0]  blue_q;
	logic        frame_valid_q;
	logic        status_q;

	slpg_cat_t              cat;
	logic [9:0]             p_raw;
	logic [9:0]             p_eff;
	logic [8:0]             half;
	logic [8:0]             blink_half;
	logic [9:0]             blink_eff;
	logic [7:0]             peak_sel;
	logic [9:0]             up;
	logic [17:0]            prod;
	logic [7:0]             lvl;
	logic [15:0]            amb_prod;
	logic                   div_start;
	logic [DIV_STEPS_W-1:0] div_steps;
	logic [31:0]            div_dividend;
	logic [9:0]             div_divisor;
	logic                   div_done;
	logic [31:0]            quot;
	logic [9:0]             rem;
	logic [7:0]             base_r;
	logic [7:0]             base_g;
	logic [7:0]             base_b;
	logic [8:0]             sum_r;
	logic [8:0]             sum_g;
	logic [8:0]             sum_b;
	logic [7:0]             res_r;
	logic [7:0]             res_g;
	logic [7:0]             res_b;
	logic                   res_status;

	always_comb begin
		unique case (mode_q)
			MODE_MOVING:    cat = CAT_AMBER;
			MODE_READY:     cat = CAT_GREEN;
			MODE_NOT_READY: cat = CAT_ORANGE;
			MODE_WIFI:      cat = CAT_BLUE;
			default:        cat = CAT_WHITE;
		endcase
	end

	always_comb begin
		unique case (cat)
			CAT_AMBER:  p_raw = fast_period_q;
			CAT_ORANGE: p_raw = blink_period_q;
			default:    p_raw = slow_period_q;
		endcase
	end

	assign p_eff      = (p_raw < 10'd2) ? 10'd2 : p_raw;
	assign half       = p_eff[9:1];
	assign blink_eff  = (blink_period_q < 10'd2) ? 10'd2 : blink_period_q;
	assign blink_half = blink_eff[9:1];

	always_comb begin
		unique case (cat)
			CAT_AMBER, CAT_GREEN: peak_sel = breath_peak_q;
			CAT_BLUE:             peak_sel = div3(breath_peak_q);
			default:              peak_sel = {2'b00, breath_peak_q[7:2]};
		endcase
	end

	// fold the phase into a triangle
	assign up       = (rem < {1'b0, half}) ? rem : (p_eff - rem);
	assign prod     = 18'(up) * 18'(peak_sel);
	assign lvl      = sat8(quot[17:0]);
	assign amb_prod = 16'(lvl) * AMBER_R_GAIN;

	assign div_start = cmd.start_mod | cmd.start_lvl | cmd.start_amb;

	always_comb begin
		div_steps    = DIV_STEPS_MOD;
		div_dividend = tick_count_q;
		div_divisor  = p_eff;
		priority if (cmd.start_lvl) begin
			div_steps    = DIV_STEPS_LVL;
			div_dividend = {prod, 14'b0};
			div_divisor  = {1'b0, half};
		end else if (cmd.start_amb) begin
			div_steps    = DIV_STEPS_AMB;
			div_dividend = {amb_prod, 16'b0};
			div_divisor  = {2'b00, breath_peak_q};
		end
	end

	slpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	// frame color: red in the error hold, else from what the divider holds at the end of the request
	always_comb begin
		base_r = '0;
		base_g = '0;
		base_b = '0;
		if (error_count_q != 16'd0) begin
			base_r = RED_HOLD_R;
		end else begin
			unique case (cat)
				CAT_AMBER: begin
					if (breath_peak_q != 8'd0) begin
						base_r = sat8({2'b00, quot[15:0]});
						base_g = sat8({3'b000, quot[15:1]});
					end
				end
				CAT_GREEN: base_g = lvl;
				CAT_ORANGE: begin
					if (rem < {1'b0, blink_half}) begin
						base_r = ORANGE_R;
						base_g = ORANGE_G;
					end
				end
				CAT_BLUE: base_b = lvl;
				default: begin
					base_r = lvl;
					base_g = lvl;
					base_b = lvl;
				end
			endcase
		end
	end

	assign sum_r = {1'b0, base_r} + {1'b0, flash_red_q};
	assign sum_g = {1'b0, base_g} + {1'b0, flash_green_q};
	assign sum_b = {1'b0, base_b} + {1'b0, flash_blue_q};

	always_comb begin
		res_r      = '0;
		res_g      = '0;
		res_b      = '0;
		res_status = 1'b0;
		unique case (func_q)
			FUNC_TICK: begin
				if (flash_count_q != 8'd0) begin
					res_r = sum_r[8:1];
					res_g = sum_g[8:1];
					res_b = sum_b[8:1];
				end else begin
					res_r = base_r;
					res_g = base_g;
					res_b = base_b;
				end
			end
			FUNC_STATE: res_status = new_mode_q > MODE_ERROR;
			FUNC_EVENT: res_status = (kind_q != KIND_READ) && (kind_q != KIND_WRITE) &&
				(kind_q != KIND_ERROR);
			default:    res_status = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q     <= func;
			new_mode_q <= new_mode;
			kind_q     <= activity_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slow_period_q  <= 10'd120;
			fast_period_q  <= 10'd40;
			blink_period_q <= 10'd80;
			error_hold_q   <= 16'd200;
			flash_hold_q   <= 8'd2;
			breath_peak_q  <= 8'd70;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOW_PERIOD:  slow_period_q  <= cfg_data[9:0];
				CFG_FAST_PERIOD:  fast_period_q  <= cfg_data[9:0];
				CFG_BLINK_PERIOD: blink_period_q <= cfg_data[9:0];
				CFG_ERROR_HOLD:   error_hold_q   <= cfg_data;
				CFG_FLASH_HOLD:   flash_hold_q   <= cfg_data[7:0];
				CFG_BREATH_PEAK:  breath_peak_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_BOOT;
			error_count_q <= '0;
			flash_red_q   <= '0;
			flash_green_q <= '0;
			flash_blue_q  <= '0;
			flash_count_q <= '0;
			tick_count_q  <= '0;
		end else if (cmd.commit) begin
			unique case (func_q)
				FUNC_TICK: begin
					tick_count_q <= tick_count_q + 32'd1;
					if (error_count_q != 16'd0) begin
						error_count_q <= error_count_q - 16'd1;
					end
					if (flash_count_q != 8'd0) begin
						flash_count_q <= flash_count_q - 8'd1;
					end
				end
				FUNC_STATE: begin
					if (new_mode_q <= MODE_ERROR) begin
						mode_q <= new_mode_q;
						if (new_mode_q == MODE_ERROR) begin
							error_count_q <= error_hold_q;
						end
					end
				end
				FUNC_EVENT: begin
					unique case (kind_q)
						KIND_READ: begin
							flash_red_q   <= 8'd0;
							flash_green_q <= 8'd120;
							flash_blue_q  <= 8'd120;
							flash_count_q <= flash_hold_q;
						end
						KIND_WRITE: begin
							flash_red_q   <= 8'd120;
							flash_green_q <= 8'd0;
							flash_blue_q  <= 8'd80;
							flash_count_q <= flash_hold_q;
						end
						KIND_ERROR: begin
							flash_red_q   <= 8'd180;
							flash_green_q <= 8'd0;
							flash_blue_q  <= 8'd0;
							flash_count_q <= flash_hold_q;
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			red_q         <= res_r;
			green_q       <= res_g;
			blue_q        <= res_b;
			frame_valid_q <= func_q == FUNC_TICK;
			status_q      <= res_status;
		end
	end

	assign sts.is_tick    = func_q == FUNC_TICK;
	assign sts.err_active = error_count_q != 16'd0;
	assign sts.blink      = cat == CAT_ORANGE;
	assign sts.amber      = cat == CAT_AMBER;
	assign sts.peak_zero  = breath_peak_q == 8'd0;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign frame_valid = frame_valid_q;
	assign status      = status_q;

endmodule

[rtl/core/slpg_chk.sv]
module slpg_chk import slpg_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [7:0]             red,
	input logic [7:0]             green,
	input logic [7:0]             blue,
	input logic                   frame_valid,
	input logic                   status
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
			$stable(red) && $stable(green) && $stable(blue) &&
			$stable(frame_valid) && $stable(status))
		else $error("stalled result changed");

	// a request occupies the block for at least the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken back to back");

	a_nonframe_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("color on a non-frame result");

	a_frame_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |-> !status)
		else $error("frame flagged invalid");

endmodule

bind status_led_pattern_generator slpg_chk u_slpg_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.red         (red),
	.green       (green),
	.blue        (blue),
	.frame_valid (frame_valid),
	.status      (status)
);
